/* rtl/u8u16_pkg.sv */
// u8u16_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; used by the interfaces, the decoder, the output queue and the top level
`default_nettype none

package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccW   = 32;
  localparam int unsigned RemW   = 3;
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] ContMark   = 8'h80;
  localparam logic [ByteW-1:0] Lead3Min   = 8'he0;
  localparam logic [ByteW-1:0] Lead4Min   = 8'hf0;
  localparam logic [ByteW-1:0] Lead5Min   = 8'hf8;
  localparam logic [ByteW-1:0] Lead6Min   = 8'hfc;
  localparam logic [ByteW-1:0] Prefix2    = 8'hc0;
  localparam logic [ByteW-1:0] Prefix3    = 8'he0;
  localparam logic [ByteW-1:0] Prefix4    = 8'hf0;
  localparam logic [ByteW-1:0] Prefix5    = 8'hf8;
  localparam logic [ByteW-1:0] Prefix6    = 8'hfc;
  localparam logic [UnitW-1:0] HiSurrBase = 16'hd7c0;
  localparam logic [5:0]       LoSurrTag  = 6'b110111;
  localparam logic [UnitW-1:0] ReplChar   = 16'hfffd;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             replaced;
    logic             last_unit;
  } unit_t;

  // what one accepted byte produces: no unit, one unit or a surrogate pair
  typedef struct packed {
    logic [1:0] count;
    unit_t      u0;
    unit_t      u1;
  } dec_out_t;

endpackage

`default_nettype wire

/* rtl/u8u16_ifs.sv */
// u8u16_byte_if and u8u16_unit_if: valid/ready channels for bytes in and code units out
// depends on u8u16_pkg for field widths
`default_nettype none

interface u8u16_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8u16_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic                        valid;
  logic                        ready;
  logic [u8u16_pkg::UnitW-1:0] code_unit;
  logic                        replaced;
  logic                        last_unit;

  modport source (output valid, output code_unit, output replaced, output last_unit,
                  input ready);
  modport sink   (input valid, input code_unit, input replaced, input last_unit,
                  output ready);
endinterface

`default_nettype wire

/* rtl/u8u16_decode.sv */
// u8u16_decode: sequence state and code point assembly, one byte per transfer
// depends on u8u16_pkg
`default_nettype none

module u8u16_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        byte_fire,
  input  wire logic [u8u16_pkg::ByteW-1:0] in_byte,
  output u8u16_pkg::dec_out_t              dec_out
);

  logic [u8u16_pkg::AccW-1:0] acc_r, acc_nxt;
  logic [u8u16_pkg::RemW-1:0] rem_r, rem_nxt;
  logic [u8u16_pkg::AccW-1:0] cp;
  logic [u8u16_pkg::ByteW-1:0] prefix;
  logic [u8u16_pkg::RemW-1:0]  lead_rem;
  u8u16_pkg::dec_out_t         emit;

  // continuation byte shifted in, held to 32 bits
  assign cp = {acc_r[u8u16_pkg::AccW-7:0], 6'b0}
            ^ {{(u8u16_pkg::AccW-u8u16_pkg::ByteW){1'b0}}, in_byte ^ u8u16_pkg::ContMark};

  always_comb begin
    if (in_byte < u8u16_pkg::Lead3Min) begin
      prefix = u8u16_pkg::Prefix2;  lead_rem = 3'd1;
    end else if (in_byte < u8u16_pkg::Lead4Min) begin
      prefix = u8u16_pkg::Prefix3;  lead_rem = 3'd2;
    end else if (in_byte < u8u16_pkg::Lead5Min) begin
      prefix = u8u16_pkg::Prefix4;  lead_rem = 3'd3;
    end else if (in_byte < u8u16_pkg::Lead6Min) begin
      prefix = u8u16_pkg::Prefix5;  lead_rem = 3'd4;
    end else begin
      prefix = u8u16_pkg::Prefix6;  lead_rem = 3'd5;
    end
  end

  always_comb begin
    emit          = '0;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    emit.u0.last_unit = 1'b1;
    if (rem_r != '0) begin
      rem_nxt = rem_r - 3'd1;
      acc_nxt = cp;
      if (rem_r == 3'd1) begin
        acc_nxt    = '0;
        emit.count = 2'd1;
        if (cp == '0) begin
          emit.u0.code_unit = u8u16_pkg::ReplChar;
          emit.u0.replaced  = 1'b1;
        end else if (cp[31:16] == '0) begin
          emit.u0.code_unit = cp[15:0];
        end else if (cp[31:21] == '0 && cp[20:16] != 5'h11 && cp[20] == 1'b0 ||
                     cp[31:21] == '0 && cp[20:16] == 5'h10) begin
          // surrogate pair for planes one to sixteen
          emit.count        = 2'd2;
          emit.u0.code_unit = {5'b0, cp[20:10]} + u8u16_pkg::HiSurrBase;
          emit.u0.last_unit = 1'b0;
          emit.u1.code_unit = {u8u16_pkg::LoSurrTag, cp[9:0]};
          emit.u1.last_unit = 1'b1;
        end else begin
          emit.u0.code_unit = u8u16_pkg::ReplChar;
          emit.u0.replaced  = 1'b1;
        end
      end
    end else if (in_byte < u8u16_pkg::ContMark) begin
      emit.count        = 2'd1;
      emit.u0.code_unit = {8'b0, in_byte};
    end else begin
      acc_nxt = {{(u8u16_pkg::AccW-u8u16_pkg::ByteW){1'b0}}, in_byte ^ prefix};
      rem_nxt = lead_rem;
    end
  end

  assign dec_out = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
    end else if (byte_fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/u8u16_outq.sv */
// u8u16_outq: three-entry register queue that holds code units until the sink takes them
// depends on u8u16_pkg
`default_nettype none

module u8u16_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire u8u16_pkg::dec_out_t dec_out,
  output logic                    can_take,
  output logic                    head_valid,
  output u8u16_pkg::unit_t        head,
  input  wire logic               head_taken
);

  u8u16_pkg::unit_t              q_r   [u8u16_pkg::QDepth];
  u8u16_pkg::unit_t              q_nxt [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QCntW-1:0]   cnt_r, cnt_nxt;
  logic [u8u16_pkg::QCntW-1:0]   base;
  logic [u8u16_pkg::QCntW-1:0]   add;
  logic                          pop;

  // room for a pair whatever the sink does this cycle
  assign can_take   = (cnt_r <= u8u16_pkg::QCntW'(u8u16_pkg::QDepth - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && head_taken;
  assign base       = cnt_r - u8u16_pkg::QCntW'(pop);
  assign add        = push ? u8u16_pkg::QCntW'(dec_out.count) : '0;
  assign cnt_nxt    = base + add;

  always_comb begin
    for (int i = 0; i < u8u16_pkg::QDepth; i++) begin
      if (pop && i < u8u16_pkg::QDepth - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (add != '0 && u8u16_pkg::QCntW'(i) == base) begin
        q_nxt[i] = dec_out.u0;
      end
      if (add == u8u16_pkg::QCntW'(2) && u8u16_pkg::QCntW'(i) == base + 1'b1) begin
        q_nxt[i] = dec_out.u1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < u8u16_pkg::QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8_to_utf16_transcoder.sv */
// utf8_to_utf16_transcoder: top level, byte channel in, utf-16 code unit channel out
// depends on u8u16_pkg, u8u16_ifs, u8u16_decode and u8u16_outq
//
// Takes one UTF-8 byte per transfer and gives UTF-16 code units. A byte is
// decoded in the cycle it is taken; the units it completes (none, one, or a
// surrogate pair with last_unit low on the high half) enter a three-entry
// output queue and appear from the next cycle on. The input accepts a byte in
// every cycle while at most one unit is queued, so plain text runs at one byte
// per cycle with the sink ready; a surrogate pair gives two output units, and
// the output side sets the rate then. A zero or out-of-range code point comes
// out as U+FFFD with replaced set. Input is not validated.
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire logic     clk,
  input  wire logic     rst_n,
  u8u16_byte_if.sink    in_if,
  u8u16_unit_if.source  out_if
);

  logic                byte_fire;
  logic                can_take;
  u8u16_pkg::dec_out_t dec_out;
  u8u16_pkg::unit_t    head;

  assign in_if.ready = can_take;
  assign byte_fire   = in_if.valid && can_take;

  u8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .in_byte   (in_if.in_byte),
    .dec_out   (dec_out)
  );

  u8u16_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (byte_fire),
    .dec_out    (dec_out),
    .can_take   (can_take),
    .head_valid (out_if.valid),
    .head       (head),
    .head_taken (out_if.ready)
  );

  assign out_if.code_unit = head.code_unit;
  assign out_if.replaced  = head.replaced;
  assign out_if.last_unit = head.last_unit;

endmodule

`default_nettype wire
